>>> rtl/tasrg_pkg.sv
// Package for the three-axis stepper ramp generator.
// Holds widths, item kinds, register indexes and shared structs; no dependencies.
package tasrg_pkg;
	localparam int AXES_DEF = 3;
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_MOVE = 2'd1;
	localparam logic [1:0] KIND_STOP = 2'd2;
	localparam logic REG_START = 1'b0;
	localparam logic REG_DEC = 1'b1;
	localparam logic [31:0] TOL_US = 32'd50;
	localparam logic [32:0] READY_MARGIN = 33'd20;
	localparam logic [31:0] NO_PERIOD = 32'hFFFFFFFF;

	typedef struct packed {
		logic start;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [63:0] quo;
	} div_rsp_t;
endpackage

>>> rtl/tasrg_div.sv
// Radix-2 restoring divider for a 64-bit quotient, one quotient bit per cycle.
// Depends on tasrg_pkg for the request and response structs.
module tasrg_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tasrg_pkg::div_req_t req,
	output tasrg_pkg::div_rsp_t rsp
);
	import tasrg_pkg::*;
	logic [63:0] rem_q, quo_q, den_q;
	logic [6:0] cnt_q;
	logic busy_q, done_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};
	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule

>>> rtl/tasrg_lane.sv
// One axis lane: step decision and next step time on service ticks.
// Depends on tasrg_pkg; loaded and ramped by the top-level sequencer.
module tasrg_lane (
	input  logic        tick,
	input  logic [31:0] time_now,
	input  logic [31:0] period,
	input  logic [31:0] last_time,
	output logic        fire,
	output logic [31:0] next_last
);
	import tasrg_pkg::*;
	logic [31:0] elapsed;
	assign elapsed = time_now - last_time + TOL_US;
	assign fire = tick && (period != 32'd0) && (elapsed >= period);
	assign next_last = last_time + period;
endmodule

>>> rtl/three_axis_stepper_ramp_generator.sv
// Three-axis stepper ramp generator top level; needs tasrg_pkg, tasrg_lane and tasrg_div.
// A tick request passes the tick state before its result; a stop request does not.
// A move runs up to 10 divisions on one shared divider, fewer for idle axes.
// One request is in work at a time; the next is taken the cycle after the result leaves.
// Active-low async reset clears all but the divider data; registers reset to 2000, 10.
module three_axis_stepper_ramp_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] time_now,
	input  logic [15:0] steps_left_wheel,
	input  logic [15:0] steps_right_wheel,
	input  logic [15:0] steps_back_wheel,
	input  logic        dir_left_wheel,
	input  logic        dir_right_wheel,
	input  logic        dir_back_wheel,
	input  logic [22:0] duration_ms,
	input  logic        is_extension,
	input  logic        with_decel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        step_pulse_left,
	output logic        step_pulse_right,
	output logic        step_pulse_back,
	output logic        dir_out_left,
	output logic        dir_out_right,
	output logic        dir_out_back,
	output logic        is_moving,
	output logic        ready_for_next,
	output logic [31:0] service_interval_us,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [19:0] cfg_data
);
	import tasrg_pkg::*;
	localparam int AXIS_COUNT = AXES_DEF;
	localparam int AW = $clog2(AXIS_COUNT);
	localparam logic [AW-1:0] LAST_AX = AW'(AXIS_COUNT - 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_TGT   = 4'd1;
	localparam logic [3:0] ST_PICK  = 4'd2;
	localparam logic [3:0] ST_RLEN  = 4'd3;
	localparam logic [3:0] ST_RST   = 4'd4;
	localparam logic [3:0] ST_DELTA = 4'd5;
	localparam logic [3:0] ST_FIN   = 4'd6;
	localparam logic [3:0] ST_TICK  = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;
	localparam logic [3:0] ST_WAIT  = 4'd9;

	logic [3:0] state_q, ret_q;
	logic [19:0] start_q;
	logic [15:0] dec_q;
	logic [31:0] rem_q [AXIS_COUNT];
	logic [31:0] tgt_q [AXIS_COUNT];
	logic [31:0] cur_q [AXIS_COUNT];
	logic [31:0] dlt_q [AXIS_COUNT];
	logic [31:0] last_q [AXIS_COUNT];
	logic [31:0] rs_q [AXIS_COUNT];
	logic [AXIS_COUNT-1:0] dir_q, pulse_q, fire;
	logic [AW-1:0] major_q, ax_q, major_n;
	logic accel_q, en_q, ext_q;
	logic [31:0] rlen_q, short_q, time_q, short_n, rem_mj, mrem;
	logic [15:0] stp_q [AXIS_COUNT];
	logic [22:0] dur_q;
	logic [31:0] nlast [AXIS_COUNT];
	logic tail, lane_tick, div_go;
	div_req_t dreq;
	div_rsp_t drsp;
	logic [31:0] quo_sat;
	logic [15:0] dec_eff;

	assign dec_eff = (dec_q == 16'd0) ? 16'd1 : dec_q;
	assign quo_sat = (drsp.quo[63:32] != 32'd0) ? NO_PERIOD : drsp.quo[31:0];
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = (state_q == ST_OUT);

	assign {step_pulse_back, step_pulse_right, step_pulse_left} = pulse_q;
	assign dir_out_left = dir_q[0];
	assign dir_out_right = dir_q[1];
	assign dir_out_back = dir_q[2];
	assign service_interval_us = short_q;
	assign rem_mj = rem_q[major_q];
	assign is_moving = ($signed(rem_mj) > 32'sd0) && en_q;
	assign ready_for_next = (accel_q && ($signed({{2{rem_mj[31]}}, rem_mj}) <=
			$signed({1'b0, {1'b0, rlen_q} + READY_MARGIN}))) ||
		($signed({{2{rem_mj[31]}}, rem_mj}) <= $signed({1'b0, READY_MARGIN})) || !is_moving;

	assign mrem = rem_mj - {31'd0, fire[major_q]};
	assign tail = $signed({mrem[31], mrem}) <= $signed({1'b0, rlen_q});
	assign lane_tick = (state_q == ST_TICK) && en_q;
	assign div_go = (state_q == ST_TGT && stp_q[ax_q] != 16'd0) || state_q == ST_RLEN ||
		state_q == ST_RST || (state_q == ST_DELTA && rlen_q != 32'd0);

	tasrg_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_lane
		tasrg_lane u_lane (
			.tick(lane_tick), .time_now(time_q),
			.period(cur_q[g]), .last_time(last_q[g]),
			.fire(fire[g]), .next_last(nlast[g])
		);
	end

	always_comb begin
		short_n = NO_PERIOD;
		major_n = '0;
		for (int i = 0; i < AXIS_COUNT; i++) begin
			if (tgt_q[i] != 32'd0 && tgt_q[i] < short_n) begin
				short_n = tgt_q[i];
				major_n = AW'(i);
			end
		end
	end

	always_comb begin
		logic [63:0] span, p, d;
		span = {44'd0, start_q} - {32'd0, short_q};
		p = {32'd0, tgt_q[ax_q]};
		d = (rs_q[ax_q] >= tgt_q[ax_q]) ? {32'd0, rs_q[ax_q] - tgt_q[ax_q]} : 64'd0;
		dreq = '0;
		dreq.start = div_go;
		if (state_q == ST_TGT) begin
			dreq.num = {41'd0, dur_q} * 64'd1000;
			dreq.den = {48'd0, stp_q[ax_q]};
		end else if (state_q == ST_RLEN) begin
			dreq.num = (span << 1) + {48'd0, dec_eff};
			dreq.den = {47'd0, dec_eff, 1'b0};
		end else if (state_q == ST_RST) begin
			dreq.num = ((p * {44'd0, start_q}) << 1) + {32'd0, short_q};
			dreq.den = {31'd0, short_q, 1'b0};
		end else begin
			dreq.num = (d << 1) + {32'd0, rlen_q};
			dreq.den = {31'd0, rlen_q, 1'b0};
		end
	end

	// Sequencer for moves, ticks and stops; the division steps share one divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			start_q <= 20'd2000;
			dec_q <= 16'd10;
			for (int i = 0; i < AXIS_COUNT; i++) begin
				rem_q[i] <= '0; tgt_q[i] <= '0; cur_q[i] <= '0;
				dlt_q[i] <= '0; last_q[i] <= '0; rs_q[i] <= '0; stp_q[i] <= '0;
			end
			dir_q <= '0; pulse_q <= '0; major_q <= '0; accel_q <= 1'b0;
			rlen_q <= '0; en_q <= 1'b0; short_q <= '0; ext_q <= 1'b0;
			ax_q <= '0; time_q <= '0; dur_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_START) start_q <= cfg_data;
				else dec_q <= cfg_data[15:0];
			end
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					time_q <= time_now;
					ax_q <= '0;
					pulse_q <= '0;
					if (kind == KIND_MOVE) begin
						stp_q[0] <= steps_left_wheel;
						stp_q[1] <= steps_right_wheel;
						stp_q[2] <= steps_back_wheel;
						rem_q[0] <= {16'd0, steps_left_wheel};
						rem_q[1] <= {16'd0, steps_right_wheel};
						rem_q[2] <= {16'd0, steps_back_wheel};
						dir_q <= {dir_back_wheel, dir_right_wheel, dir_left_wheel};
						for (int i = 0; i < AXIS_COUNT; i++) last_q[i] <= time_now;
						dur_q <= duration_ms;
						ext_q <= is_extension;
						state_q <= ST_TGT;
					end else if (kind == KIND_STOP) begin
						if (with_decel && accel_q) rem_q[major_q] <= rlen_q;
						else begin
							en_q <= 1'b0;
							rem_q[major_q] <= '0;
						end
						state_q <= ST_OUT;
					end else state_q <= ST_TICK;
				end
				ST_TGT: if (stp_q[ax_q] == 16'd0) begin
					tgt_q[ax_q] <= '0;
					if (ax_q == LAST_AX) begin
						ax_q <= '0;
						state_q <= ST_PICK;
					end else ax_q <= ax_q + 1'b1;
				end else begin
					ret_q <= ST_TGT;
					state_q <= ST_WAIT;
				end
				ST_PICK: begin
					short_q <= short_n;
					major_q <= major_n;
					accel_q <= short_n < {12'd0, start_q};
					state_q <= (short_n < {12'd0, start_q}) ? ST_RLEN : ST_FIN;
				end
				ST_RLEN: begin
					ret_q <= ST_RLEN;
					state_q <= ST_WAIT;
				end
				ST_RST: begin
					ret_q <= ST_RST;
					state_q <= ST_WAIT;
				end
				ST_DELTA: if (rlen_q == 32'd0) begin
					dlt_q[ax_q] <= '0;
					if (ax_q == LAST_AX) begin
						ax_q <= '0;
						state_q <= ST_FIN;
					end else begin
						ax_q <= ax_q + 1'b1;
						state_q <= ST_RST;
					end
				end else begin
					ret_q <= ST_DELTA;
					state_q <= ST_WAIT;
				end
				ST_WAIT: if (drsp.done) begin
					unique case (ret_q)
						ST_TGT: begin
							tgt_q[ax_q] <= quo_sat;
							if (ax_q == LAST_AX) begin
								ax_q <= '0;
								state_q <= ST_PICK;
							end else begin
								ax_q <= ax_q + 1'b1;
								state_q <= ST_TGT;
							end
						end
						ST_RLEN: begin
							rlen_q <= drsp.quo[31:0];
							ax_q <= '0;
							state_q <= ST_RST;
						end
						ST_RST: begin
							rs_q[ax_q] <= quo_sat;
							state_q <= ST_DELTA;
						end
						ST_DELTA: begin
							dlt_q[ax_q] <= drsp.quo[31:0];
							if (ax_q == LAST_AX) begin
								ax_q <= '0;
								state_q <= ST_FIN;
							end else begin
								ax_q <= ax_q + 1'b1;
								state_q <= ST_RST;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_FIN: begin
					for (int i = 0; i < AXIS_COUNT; i++) begin
						if (accel_q) cur_q[i] <= ext_q ? tgt_q[i] : rs_q[i];
						else begin
							cur_q[i] <= tgt_q[i];
							dlt_q[i] <= '0;
						end
					end
					en_q <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_TICK: begin
					pulse_q <= fire;
					for (int i = 0; i < AXIS_COUNT; i++) begin
						if (fire[i]) begin
							last_q[i] <= nlast[i];
							rem_q[i] <= rem_q[i] - 32'd1;
						end
					end
					if (en_q) begin
						if (accel_q) begin
							if (!tail && cur_q[major_q] > tgt_q[major_q]) begin
								for (int i = 0; i < AXIS_COUNT; i++)
									cur_q[i] <= cur_q[i] - dlt_q[i];
							end else if (tail && cur_q[major_q] < {12'd0, start_q}) begin
								for (int i = 0; i < AXIS_COUNT; i++)
									cur_q[i] <= cur_q[i] + dlt_q[i];
							end
						end
						if ($signed(mrem) <= 32'sd0) en_q <= 1'b0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> tb/three_axis_stepper_ramp_generator_test.sv
// Self-checking testbench for the three-axis stepper ramp generator.
// Needs tasrg_pkg and the top level; predicts each result from its own model of the block.
`timescale 1ns / 100ps
module three_axis_stepper_ramp_generator_test;
	import tasrg_pkg::*;

	localparam logic [1:0] KIND_UNDEF = 2'd3;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] stamp;
		logic [2:0][15:0] steps;
		logic [2:0] dirs;
		logic [22:0] dur;
		logic ext;
		logic decel;
	} request_t;

	typedef struct packed {
		logic [2:0] pulse;
		logic [2:0] dir;
		logic moving;
		logic ready;
		logic [31:0] interval;
	} status_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] kind = 0;
	logic [31:0] time_now = 0;
	logic [15:0] steps_left_wheel = 0, steps_right_wheel = 0, steps_back_wheel = 0;
	logic dir_left_wheel = 0, dir_right_wheel = 0, dir_back_wheel = 0;
	logic [22:0] duration_ms = 0;
	logic is_extension = 0, with_decel = 0;
	logic out_valid;
	logic out_stall = 0;
	logic step_pulse_left, step_pulse_right, step_pulse_back;
	logic dir_out_left, dir_out_right, dir_out_back;
	logic is_moving, ready_for_next;
	logic [31:0] service_interval_us;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_index = 0;
	logic [19:0] cfg_data = 0;

	three_axis_stepper_ramp_generator dut (.*);

	always #1 clk = ~clk;

	// Predictor state.
	logic [19:0] start_us;
	logic [15:0] dec_us;
	logic [31:0] remaining [3];
	logic [31:0] target [3];
	logic [31:0] period [3];
	logic [31:0] delta [3];
	logic [31:0] last_step [3];
	logic [2:0] dir_state;
	logic [1:0] major;
	logic ramping;
	logic [31:0] ramp_len;
	logic enabled;
	logic [31:0] shortest;

	status_t expected_status [$];
	int fails = 0;
	int cycles = 0;
	bit calm = 0;
	logic [31:0] host_us;
	bit took_result = 0;
	int stall_left = 0;

	function automatic logic [31:0] clip32(input logic [63:0] v);
		return v > 64'hFFFFFFFF ? 32'hFFFFFFFF : v[31:0];
	endfunction

	function automatic bit moving_now();
		return $signed(remaining[major]) > 0 && enabled;
	endfunction

	function automatic status_t predict_status(input request_t r);
		status_t s;
		logic [63:0] dec, span, rs_start, diff;
		longint m;
		s = '0;
		if (r.kind == KIND_MOVE) begin
			dec = dec_us == 0 ? 64'd1 : 64'(dec_us);
			for (int i = 0; i < 3; i++) begin
				target[i] = r.steps[i] != 0 ?
					clip32(64'(r.dur) * 1000 / 64'(r.steps[i])) : 32'd0;
				remaining[i] = 32'(r.steps[i]);
				dir_state[i] = r.dirs[i];
			end
			shortest = NO_PERIOD;
			major = 2'd0;
			for (int i = 0; i < 3; i++)
				if (target[i] != 0 && target[i] < shortest) begin
					shortest = target[i];
					major = 2'(i);
				end
			ramping = shortest < 32'(start_us);
			if (ramping) begin
				span = 64'(32'(start_us) - shortest);
				ramp_len = 32'((2 * span + dec) / (2 * dec));
				for (int i = 0; i < 3; i++) begin
					rs_start = 64'(clip32((2 * 64'(target[i]) * 64'(start_us) + 64'(shortest))
						/ (2 * 64'(shortest))));
					diff = rs_start >= 64'(target[i]) ? rs_start - 64'(target[i]) : 64'd0;
					delta[i] = ramp_len != 0 ?
						32'((2 * diff + 64'(ramp_len)) / (2 * 64'(ramp_len))) : 32'd0;
					period[i] = r.ext ? target[i] : rs_start[31:0];
				end
			end else begin
				for (int i = 0; i < 3; i++) begin
					period[i] = target[i];
					delta[i] = '0;
				end
			end
			for (int i = 0; i < 3; i++)
				last_step[i] = r.stamp;
			enabled = 1'b1;
		end else if (r.kind == KIND_STOP) begin
			if (r.decel && ramping) begin
				remaining[major] = ramp_len;
			end else begin
				enabled = 1'b0;
				remaining[major] = '0;
			end
		end else if (enabled) begin
			for (int i = 0; i < 3; i++)
				if (period[i] != 0 && r.stamp - last_step[i] + TOL_US >= period[i]) begin
					s.pulse[i] = 1'b1;
					last_step[i] += period[i];
					remaining[i] -= 32'd1;
				end
			m = longint'($signed(remaining[major]));
			if (ramping) begin
				if (m > longint'(ramp_len) && period[major] > target[major]) begin
					for (int i = 0; i < 3; i++)
						period[i] -= delta[i];
				end else if (m <= longint'(ramp_len) && period[major] < 32'(start_us)) begin
					for (int i = 0; i < 3; i++)
						period[i] += delta[i];
				end
			end
			if (m <= 0)
				enabled = 1'b0;
		end
		m = longint'($signed(remaining[major]));
		s.dir = dir_state;
		s.moving = moving_now();
		s.ready = (ramping && m <= longint'(ramp_len) + 20) || m <= 20 || !moving_now();
		s.interval = shortest;
		return s;
	endfunction

	task automatic send_request(input request_t r);
		int gap;
		bit stalled;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		kind <= r.kind;
		time_now <= r.stamp;
		steps_left_wheel <= r.steps[0];
		steps_right_wheel <= r.steps[1];
		steps_back_wheel <= r.steps[2];
		dir_left_wheel <= r.dirs[0];
		dir_right_wheel <= r.dirs[1];
		dir_back_wheel <= r.dirs[2];
		duration_ms <= r.dur;
		is_extension <= r.ext;
		with_decel <= r.decel;
		in_valid <= 1;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		expected_status.push_back(predict_status(r));
	endtask

	task automatic write_register(input logic idx, input logic [19:0] value);
		bit granted;
		in_valid <= 0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1;
		do begin
			@(negedge clk);
			granted = cfg_ready;
			@(posedge clk);
		end while (!granted);
		cfg_valid <= 0;
		if (idx == REG_START)
			start_us = value;
		else
			dec_us = value[15:0];
	endtask

	function automatic request_t blank_request(input logic [1:0] k);
		request_t r;
		r = '0;
		r.kind = k;
		r.stamp = host_us;
		return r;
	endfunction

	task automatic send_tick(input logic [31:0] advance);
		host_us += advance;
		send_request(blank_request(KIND_TICK));
	endtask

	task automatic send_stop(input bit decel);
		request_t r;
		r = blank_request(KIND_STOP);
		r.decel = decel;
		send_request(r);
	endtask

	task automatic send_move(input int s0, input int s1, input int s2, input int dur,
			input bit ext);
		request_t r;
		r = blank_request(KIND_MOVE);
		r.steps[0] = 16'(s0);
		r.steps[1] = 16'(s1);
		r.steps[2] = 16'(s2);
		r.dirs = 3'($urandom);
		r.dur = 23'(dur);
		r.ext = ext;
		send_request(r);
	endtask

	task automatic send_noise();
		request_t r;
		r.kind = 2'($urandom);
		r.stamp = $urandom;
		r.steps = {16'($urandom), 16'($urandom), 16'($urandom)};
		r.dirs = 3'($urandom);
		r.dur = 23'($urandom);
		r.ext = 1'($urandom);
		r.decel = 1'($urandom);
		host_us = r.stamp;
		send_request(r);
	endtask

	task automatic test_directed();
		send_tick(0);
		send_stop(1);
		send_stop(0);
		host_us = 32'hFFFFFF00;
		send_move(0, 0, 0, 100, 0);
		send_request(blank_request(KIND_UNDEF));
		send_move(1, 65535, 0, 23'h7FFFFF, 0);
		send_tick(32'hFFFFFFFF);
		send_move(4, 8, 2, 4, 0);
		repeat (6) send_tick(300);
		send_stop(1);
		repeat (4) send_tick(700);
		send_move(10, 3, 5, 5, 1);
		send_tick(0);
		send_tick(450);
		send_stop(0);
		send_tick(5000);
		send_request(blank_request(KIND_UNDEF));
		send_move(65535, 65535, 65535, 0, 1);
	endtask

	task automatic test_ramped_moves(input int items);
		int n, per, most, len;
		n = 0;
		while (n < items) begin
			per = $urandom_range(60, 4000);
			most = $urandom_range(1, 60);
			send_move($urandom_range(0, 1) ? most : $urandom_range(0, most), most,
				$urandom_range(0, most), most * per / 1000 + $urandom_range(0, 2),
				$urandom_range(0, 3) == 0);
			len = $urandom_range(10, 120);
			for (int t = 0; t < len; t++) begin
				if ($urandom_range(0, 40) == 0)
					send_stop($urandom_range(0, 2) != 0);
				else
					send_tick($urandom_range(0, 2 * (shortest > 3000 ? 3000 : shortest)));
			end
			n += len + 1;
			if ($urandom_range(0, 3) == 0) begin
				send_noise();
				n++;
			end
		end
	endtask

	task automatic test_noise(input int items);
		repeat (items) send_noise();
	endtask

	always @(negedge clk) begin
		status_t got, want;
		took_result = 0;
		if (out_valid && !out_stall) begin
			took_result = 1;
			got = '{pulse: {step_pulse_back, step_pulse_right, step_pulse_left},
				dir: {dir_out_back, dir_out_right, dir_out_left},
				moving: is_moving, ready: ready_for_next, interval: service_interval_us};
			if (expected_status.size() == 0) begin
				$error("result with no request waiting");
				fails++;
			end else begin
				want = expected_status.pop_front();
				if (got.pulse != want.pulse) begin
					$error("step_pulse expected %b actual %b", want.pulse, got.pulse);
					fails++;
				end
				if (got.dir != want.dir) begin
					$error("dir_out expected %b actual %b", want.dir, got.dir);
					fails++;
				end
				if (got.moving != want.moving) begin
					$error("is_moving expected %b actual %b", want.moving, got.moving);
					fails++;
				end
				if (got.ready != want.ready) begin
					$error("ready_for_next expected %b actual %b", want.ready, got.ready);
					fails++;
				end
				if (got.interval != want.interval) begin
					$error("service_interval_us expected %0d actual %0d", want.interval,
						got.interval);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1;
		end else begin
			out_stall <= 0;
			if (took_result && !calm)
				stall_left = $urandom_range(0, 7);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[three_axis_stepper_ramp_generator] ERROR");
			$finish;
		end
	end

	initial begin
		start_us = 20'd2000;
		dec_us = 16'd10;
		for (int i = 0; i < 3; i++) begin
			remaining[i] = '0;
			target[i] = '0;
			period[i] = '0;
			delta[i] = '0;
			last_step[i] = '0;
		end
		dir_state = '0;
		major = '0;
		ramping = 1'b0;
		ramp_len = '0;
		enabled = 1'b0;
		shortest = '0;
		host_us = $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_ramped_moves(220);
		calm = 1;
		write_register(REG_START, 20'd1000000);
		write_register(REG_DEC, 20'hF0000);
		test_ramped_moves(100);
		calm = 0;
		write_register(REG_START, 20'd1);
		write_register(REG_DEC, 20'h0FFFF);
		test_ramped_moves(100);
		test_noise(60);
		write_register(REG_START, 20'd0);
		test_noise(40);
		write_register(REG_START, 20'(($urandom_range(500, 3000) << 0) | 20'h00000));
		write_register(REG_DEC, 20'($urandom_range(1, 40)) | 20'hA0000);
		test_ramped_moves(180);
		write_register(REG_START, 20'h5_5555);
		write_register(REG_DEC, 20'h5_AAAA);
		test_noise(40);
		write_register(REG_START, 20'hA_AAAA);
		write_register(REG_DEC, 20'h0_5555);
		test_ramped_moves(180);
		test_noise(60);
		in_valid <= 0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fails == 0 && expected_status.size() == 0)
			$display("[three_axis_stepper_ramp_generator] OK");
		else
			$display("[three_axis_stepper_ramp_generator] ERROR");
		$finish;
	end
endmodule

>>> sim.f
rtl/tasrg_pkg.sv
rtl/tasrg_div.sv
rtl/tasrg_lane.sv
rtl/three_axis_stepper_ramp_generator.sv
tb/three_axis_stepper_ramp_generator_test.sv
